// File: rtl/core/mlfq_pkg.sv
`timescale 1ns / 1ps
package mlfq_pkg;
   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 6;
   localparam int LEVEL_W  = 2;
   localparam int SLICE_W  = 8;
   localparam int STATUS_W = 2;
   localparam int THR_W    = 16;
   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK     = 3'd0,
      ACT_READY    = 3'd1,
      ACT_PICK     = 3'd2,
      ACT_RUN_DONE = 3'd3,
      ACT_LEAVE    = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_IGNORED = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_SLICE0    = 3'd1,
      CSR_SLICE1    = 3'd2,
      CSR_SLICE2    = 3'd3,
      CSR_SLICE3    = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SRD, S_AGE_RD, S_AGE_CHK, S_REM_RD, S_REM_SCAN,
      S_REM_MOVE, S_APPEND, S_POP_RD, S_POP_WAIT, S_RESP
   } state_type;

   typedef struct packed {
      logic              picked;
      logic [SLOT_W-1:0] picked_slot;
      logic [LEVEL_W-1:0] picked_level;
      logic [SLICE_W-1:0] slice_ticks;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot;
      logic                new_process;
      logic [SLICE_W-1:0]  elapsed;
      logic                still_ready;
   } req_type;
endpackage

// File: rtl/core/mlfq_stream_if.sv
`timescale 1ns / 1ps
interface mlfq_stream_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/mlfq_ram.sv
`timescale 1ns / 1ps
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | action, slot, new_process, elapsed, still_ready
// rsp     | out | picked, picked_slot, picked_level, slice_ticks, status
// csr     | in  | write enable, index, data (no handshake)
// A tick goes straight to the response; make_ready, run_done and leave read the
// slot entry first and, for a leave, walk the level's queue.
// A pick walks all NUM_SLOTS slots, plus a queue walk per aged slot, paced
// by the single read port of the slot and queue memories.
// Reset is synchronous and then clears all NUM_SLOTS queued flags, during
// which no beat is taken. One beat in flight; rsp holds until taken.
module multilevel_feedback_queue_scheduler #(
   parameter int NUM_SLOTS  = 64,
   parameter int NUM_LEVELS = 4
) (
   input  logic clock,
   input  logic reset,
   mlfq_stream_if.sink   req,
   mlfq_stream_if.source rsp,
   input  logic                            csr_we,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int CW = SW + 1;
   localparam int QD = NUM_LEVELS * NUM_SLOTS;
   localparam int QW = $clog2(QD);
   localparam int EW = 1 + LW + mlfq_pkg::TIME_W;   // queued, level, time
   localparam logic [LW-1:0] LAST_LEVEL = LW'(NUM_LEVELS - 1);

   // slot entry: queued flag, level, insert time
   logic          sram_we;
   logic [SW-1:0] sram_waddr, sram_raddr;
   logic [EW-1:0] sram_wdata, sram_rdata;
   logic          qram_we;
   logic [QW-1:0] qram_waddr, qram_raddr;
   logic [SW-1:0] qram_wdata, qram_rdata;

   mlfq_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_slot_ram (
      .clock(clock), .wr_en(sram_we), .wr_addr(sram_waddr), .wr_data(sram_wdata),
      .rd_addr(sram_raddr), .rd_data(sram_rdata));
   mlfq_ram #(.WIDTH(SW), .DEPTH(QD)) u_queue_ram (
      .clock(clock), .wr_en(qram_we), .wr_addr(qram_waddr), .wr_data(qram_wdata),
      .rd_addr(qram_raddr), .rd_data(qram_rdata));

   mlfq_pkg::state_type state_ff, state_in;
   mlfq_pkg::req_type   req_ff, req_in;
   mlfq_pkg::rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          clr_ff, clr_in;
   logic [SW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [mlfq_pkg::THR_W-1:0]   thr_ff;
   logic [mlfq_pkg::SLICE_W-1:0] slice_ff [4];
   logic [mlfq_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [SW-1:0] head_ff [NUM_LEVELS];
   logic [SW-1:0] head_in [NUM_LEVELS];
   logic [CW-1:0] cnt_ff  [NUM_LEVELS];
   logic [CW-1:0] cnt_in  [NUM_LEVELS];
   logic [SW-1:0] cur_ff, cur_in;          // slot being worked on
   logic [LW-1:0] lv_ff, lv_in;            // level being worked on
   logic [LW-1:0] tgt_ff, tgt_in;          // append target level
   logic [CW-1:0] k_ff, k_in;              // queue walk offset
   logic          found_ff, found_in;
   logic          aging_ff, aging_in;      // remove is part of aging

   // slot entry fields
   logic                        e_q;
   logic [LW-1:0]               e_lv;
   logic [mlfq_pkg::TIME_W-1:0] e_t;
   assign {e_q, e_lv, e_t} = sram_rdata;

   function automatic logic [QW-1:0] qaddr(input logic [LW-1:0] lv,
                                           input logic [SW-1:0] head,
                                           input logic [CW-1:0] off);
      logic [CW:0] h;
      h = {1'b0, head} + {1'b0, off};
      if (h >= (CW+1)'(NUM_SLOTS)) h = h - (CW+1)'(NUM_SLOTS);
      return QW'(lv) * QW'(NUM_SLOTS) + QW'(h[SW-1:0]);
   endfunction

   function automatic logic [mlfq_pkg::SLICE_W-1:0] lslice(input logic [LW-1:0] lv,
      input logic [mlfq_pkg::SLICE_W-1:0] s0, input logic [mlfq_pkg::SLICE_W-1:0] s1,
      input logic [mlfq_pkg::SLICE_W-1:0] s2, input logic [mlfq_pkg::SLICE_W-1:0] s3);
      logic [mlfq_pkg::SLICE_W-1:0] r;
      r = s3;
      if (32'(lv) == 0) r = s0;
      else if (32'(lv) == 1) r = s1;
      else if (32'(lv) == 2) r = s2;
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd30;
         slice_ff[0] <= 8'd1; slice_ff[1] <= 8'd3;
         slice_ff[2] <= 8'd9; slice_ff[3] <= 8'd15;
      end else if (csr_we) begin
         case (mlfq_pkg::csr_index_type'(csr_index))
            mlfq_pkg::CSR_THRESHOLD: thr_ff <= csr_data;
            mlfq_pkg::CSR_SLICE0:    slice_ff[0] <= csr_data[7:0];
            mlfq_pkg::CSR_SLICE1:    slice_ff[1] <= csr_data[7:0];
            mlfq_pkg::CSR_SLICE2:    slice_ff[2] <= csr_data[7:0];
            mlfq_pkg::CSR_SLICE3:    slice_ff[3] <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlfq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         now_ff <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         now_ff <= now_in;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            cnt_ff[i] <= cnt_in[i];
         end
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      cur_ff <= cur_in;
      lv_ff <= lv_in;
      tgt_ff <= tgt_in;
      k_ff <= k_in;
      found_ff <= found_in;
      aging_ff <= aging_in;
   end

   logic slot_ok;
   assign slot_ok = 32'(req_ff.slot) < NUM_SLOTS;

   logic [mlfq_pkg::TIME_W-1:0] waited;
   assign waited = now_ff - e_t;

   // sequencer
   always_comb begin
      logic [LW-1:0] first_lv;
      logic          any;
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      now_in = now_ff;
      head_in = head_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      lv_in = lv_ff;
      tgt_in = tgt_ff;
      k_in = k_ff;
      found_in = found_ff;
      aging_in = aging_ff;
      sram_we = 1'b0;
      sram_waddr = cur_ff;
      sram_wdata = sram_rdata;
      sram_raddr = cur_ff;
      qram_we = 1'b0;
      qram_waddr = '0;
      qram_wdata = cur_ff;
      qram_raddr = qaddr(lv_ff, head_ff[lv_ff], k_ff);
      req.ready = 1'b0;
      first_lv = '0;
      any = 1'b0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            first_lv = LW'(i);
            any = 1'b1;
         end
      end

      // release the result beat
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         mlfq_pkg::S_IDLE: begin
            if (clr_ff) begin
               // clear one slot entry per cycle after reset
               sram_we = 1'b1;
               sram_waddr = clr_cnt_ff;
               sram_wdata = '0;
               clr_cnt_in = clr_cnt_ff + SW'(1);
               if (32'(clr_cnt_ff) == NUM_SLOTS - 1) clr_in = 1'b0;
            end else if (!rsp_valid_ff) begin
               req.ready = 1'b1;
               if (req.valid) begin
                  req_in = req.payload;
                  cur_in = req.payload.slot;
                  rsp_in = '0;
                  rsp_in.status = mlfq_pkg::ST_IGNORED;
                  sram_raddr = req.payload.slot;
                  case (mlfq_pkg::action_type'(req.payload.action))
                     mlfq_pkg::ACT_TICK: begin
                        now_in = now_ff + 32'd1;
                        rsp_in.status = mlfq_pkg::ST_OK;
                        state_in = mlfq_pkg::S_RESP;
                     end
                     mlfq_pkg::ACT_PICK: begin
                        cur_in = '0;
                        sram_raddr = '0;
                        state_in = mlfq_pkg::S_AGE_RD;
                     end
                     mlfq_pkg::ACT_READY, mlfq_pkg::ACT_RUN_DONE,
                     mlfq_pkg::ACT_LEAVE: state_in = mlfq_pkg::S_SRD;
                     default: state_in = mlfq_pkg::S_RESP;
                  endcase
               end
            end
         end
         mlfq_pkg::S_SRD: begin
            // slot entry is now on the read port
            aging_in = 1'b0;
            lv_in = e_lv;
            k_in = '0;
            found_in = 1'b0;
            state_in = mlfq_pkg::S_RESP;
            if (slot_ok) begin
               case (mlfq_pkg::action_type'(req_ff.action))
                  mlfq_pkg::ACT_READY: begin
                     if (!e_q) begin
                        tgt_in = req_ff.new_process ? '0 : e_lv;
                        rsp_in.status = mlfq_pkg::ST_OK;
                        state_in = mlfq_pkg::S_APPEND;
                     end
                  end
                  mlfq_pkg::ACT_RUN_DONE: begin
                     if (!e_q) begin
                        rsp_in.status = mlfq_pkg::ST_OK;
                        tgt_in = e_lv;
                        if (req_ff.elapsed >= lslice(e_lv, slice_ff[0], slice_ff[1],
                               slice_ff[2], slice_ff[3]) && e_lv != LAST_LEVEL)
                           tgt_in = e_lv + LW'(1);
                        if (req_ff.still_ready) state_in = mlfq_pkg::S_APPEND;
                     end
                  end
                  mlfq_pkg::ACT_LEAVE: begin
                     if (e_q) begin
                        rsp_in.status = mlfq_pkg::ST_OK;
                        state_in = mlfq_pkg::S_REM_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         mlfq_pkg::S_AGE_RD: begin
            // hold the read address while the entry comes out
            state_in = mlfq_pkg::S_AGE_CHK;
         end
         mlfq_pkg::S_AGE_CHK: begin
            if (e_q && waited >= 32'(thr_ff)) begin
               aging_in = 1'b1;
               lv_in = e_lv;
               tgt_in = (e_lv == '0) ? '0 : e_lv - LW'(1);
               k_in = '0;
               found_in = 1'b0;
               state_in = mlfq_pkg::S_REM_RD;
            end else if (32'(cur_ff) == NUM_SLOTS - 1) begin
               state_in = mlfq_pkg::S_POP_RD;
            end else begin
               cur_in = cur_ff + SW'(1);
               sram_raddr = cur_ff + SW'(1);
               state_in = mlfq_pkg::S_AGE_RD;
            end
         end
         mlfq_pkg::S_REM_RD: begin
            // walk the level queue: read offset k
            if (k_ff >= cnt_ff[lv_ff]) begin
               if (found_ff) cnt_in[lv_ff] = cnt_ff[lv_ff] - CW'(1);
               sram_we = 1'b1;
               sram_wdata = {1'b0, lv_ff, e_t};
               state_in = aging_ff ? mlfq_pkg::S_APPEND : mlfq_pkg::S_RESP;
            end else begin
               state_in = mlfq_pkg::S_REM_SCAN;
            end
         end
         mlfq_pkg::S_REM_SCAN: begin
            // qram_rdata holds entry k; shift it down one place once found
            if (found_ff) begin
               qram_we = 1'b1;
               qram_waddr = qaddr(lv_ff, head_ff[lv_ff], k_ff - CW'(1));
               qram_wdata = qram_rdata;
            end else if (qram_rdata == cur_ff) begin
               found_in = 1'b1;
            end
            k_in = k_ff + CW'(1);
            state_in = mlfq_pkg::S_REM_RD;
         end
         mlfq_pkg::S_APPEND: begin
            if (cnt_ff[tgt_ff] < CW'(NUM_SLOTS)) begin
               qram_we = 1'b1;
               qram_waddr = qaddr(tgt_ff, head_ff[tgt_ff], cnt_ff[tgt_ff]);
               qram_wdata = cur_ff;
               cnt_in[tgt_ff] = cnt_ff[tgt_ff] + CW'(1);
               sram_we = 1'b1;
               sram_wdata = {1'b1, tgt_ff, now_ff};
            end
            if (aging_ff) begin
               if (32'(cur_ff) == NUM_SLOTS - 1) begin
                  state_in = mlfq_pkg::S_POP_RD;
               end else begin
                  cur_in = cur_ff + SW'(1);
                  sram_raddr = cur_ff + SW'(1);
                  state_in = mlfq_pkg::S_AGE_RD;
               end
            end else begin
               state_in = mlfq_pkg::S_RESP;
            end
         end
         mlfq_pkg::S_POP_RD: begin
            rsp_in.status = mlfq_pkg::ST_EMPTY;
            state_in = mlfq_pkg::S_RESP;
            if (any) begin
               lv_in = first_lv;
               qram_raddr = qaddr(first_lv, head_ff[first_lv], '0);
               state_in = mlfq_pkg::S_POP_WAIT;
            end
         end
         mlfq_pkg::S_POP_WAIT: begin
            // head slot is on the read port; fetch its entry to clear the flag
            cur_in = qram_rdata;
            sram_raddr = qram_rdata;
            head_in[lv_ff] = (32'(head_ff[lv_ff]) == NUM_SLOTS - 1) ? '0
                             : head_ff[lv_ff] + SW'(1);
            cnt_in[lv_ff] = cnt_ff[lv_ff] - CW'(1);
            rsp_in.picked = 1'b1;
            rsp_in.picked_slot = 6'(qram_rdata);
            rsp_in.picked_level = 2'(lv_ff);
            rsp_in.slice_ticks = lslice(lv_ff, slice_ff[0], slice_ff[1],
                                        slice_ff[2], slice_ff[3]);
            rsp_in.status = mlfq_pkg::ST_OK;
            aging_in = 1'b0;
            state_in = mlfq_pkg::S_SRD;
            req_in.action = mlfq_pkg::ACT_TICK;   // S_SRD then falls to the clear
            tgt_in = lv_ff;
            found_in = 1'b1;
         end
         mlfq_pkg::S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = mlfq_pkg::S_IDLE;
         end
         default: state_in = mlfq_pkg::S_IDLE;
      endcase

      // after a pop, clear the picked slot's queued flag
      if (state_ff == mlfq_pkg::S_SRD && found_ff && rsp_ff.picked
          && req_ff.action == mlfq_pkg::ACT_TICK) begin
         sram_we = 1'b1;
         sram_wdata = {1'b0, e_lv, e_t};
         rsp_in = rsp_ff;
         state_in = mlfq_pkg::S_RESP;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !(req.valid && req.ready)) else $error("beat taken during clear");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !rsp.valid) else $error("second beat in flight");
   a_rsp_only_after_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff) == mlfq_pkg::S_RESP)
      else $error("result not from response step");
`endif
endmodule

// File: tb/multilevel_feedback_queue_scheduler_tb.sv
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler_tb;

   localparam int LIMIT_CYCLES = 50000000;
   localparam int RANDOM_ITEMS = 1450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_we    = 1'b0;
   logic [mlfq_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mlfq_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   mlfq_stream_if #(.PAYLOAD_TYPE(mlfq_pkg::req_type)) req_if ();
   mlfq_stream_if #(.PAYLOAD_TYPE(mlfq_pkg::rsp_type)) rsp_if ();

   multilevel_feedback_queue_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scheduler shadow: per-slot level, entry time, queued flag and order stamp
   logic [1:0]        sh_level [64];
   logic [31:0]       sh_entry [64];
   bit                sh_queued [64];
   int unsigned       sh_order [64];
   int unsigned       order_next;
   logic [31:0]       sh_now;
   logic [15:0]       sh_thr;
   logic [7:0]        sh_slice [4];

   mlfq_pkg::req_type pending_beats [$];
   mlfq_pkg::rsp_type sched_results [$];
   int          errors;
   int unsigned cycles;
   bit          quiet;

   // append a slot at the tail of a level
   function automatic void enqueue_slot(int s, logic [1:0] lv);
      sh_level[s]  = lv;
      sh_entry[s]  = sh_now;
      sh_queued[s] = 1'b1;
      sh_order[s]  = order_next;
      order_next++;
   endfunction

   function automatic mlfq_pkg::rsp_type schedule(mlfq_pkg::req_type r);
      mlfq_pkg::rsp_type o;
      logic [1:0] lv;
      int         s;
      int         best;
      o = '0;
      o.status = mlfq_pkg::ST_IGNORED;
      s = r.slot;
      case (r.action)
         mlfq_pkg::ACT_TICK: begin
            sh_now = sh_now + 32'd1;
            o.status = mlfq_pkg::ST_OK;
         end
         mlfq_pkg::ACT_READY: begin
            if (!sh_queued[s]) begin
               if (r.new_process) sh_level[s] = 2'd0;
               enqueue_slot(s, sh_level[s]);
               o.status = mlfq_pkg::ST_OK;
            end
         end
         mlfq_pkg::ACT_PICK: begin
            // age in ascending slot order, then pop the lowest-numbered non-empty level
            for (int i = 0; i < 64; i++) begin
               if (sh_queued[i] && (sh_now - sh_entry[i]) >= {16'd0, sh_thr}) begin
                  lv = sh_level[i];
                  enqueue_slot(i, (lv > 0) ? lv - 2'd1 : 2'd0);
               end
            end
            o.status = mlfq_pkg::ST_EMPTY;
            for (int l = 0; l < 4; l++) begin
               best = -1;
               for (int i = 0; i < 64; i++)
                  if (sh_queued[i] && sh_level[i] == l &&
                      (best < 0 || sh_order[i] < sh_order[best])) best = i;
               if (best >= 0) begin
                  sh_queued[best] = 1'b0;
                  o.picked       = 1'b1;
                  o.picked_slot  = best[mlfq_pkg::SLOT_W-1:0];
                  o.picked_level = l[mlfq_pkg::LEVEL_W-1:0];
                  o.slice_ticks  = sh_slice[l];
                  o.status       = mlfq_pkg::ST_OK;
                  break;
               end
            end
         end
         mlfq_pkg::ACT_RUN_DONE: begin
            if (!sh_queued[s]) begin
               if (r.still_ready) begin
                  lv = sh_level[s];
                  if (r.elapsed >= sh_slice[lv] && lv < 2'd3) lv = lv + 2'd1;
                  enqueue_slot(s, lv);
               end
               o.status = mlfq_pkg::ST_OK;
            end
         end
         mlfq_pkg::ACT_LEAVE: begin
            if (sh_queued[s]) begin
               sh_queued[s] = 1'b0;
               o.status = mlfq_pkg::ST_OK;
            end
         end
         default: o.status = mlfq_pkg::ST_IGNORED;
      endcase
      return o;
   endfunction

   function automatic mlfq_pkg::req_type make_beat(logic [2:0] act, int s, bit np, int el,
                                                   bit rdy);
      mlfq_pkg::req_type r;
      r.action      = act;
      r.slot        = s[mlfq_pkg::SLOT_W-1:0];
      r.new_process = np;
      r.elapsed     = el[mlfq_pkg::SLICE_W-1:0];
      r.still_ready = rdy;
      return r;
   endfunction

   function automatic mlfq_pkg::req_type random_beat();
      int  p;
      int  s;
      int  el;
      logic [2:0] act;
      p  = $urandom_range(0, 99);
      s  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
      el = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
      if (p < 30)      act = mlfq_pkg::ACT_TICK;
      else if (p < 50) act = mlfq_pkg::ACT_READY;
      else if (p < 72) act = mlfq_pkg::ACT_PICK;
      else if (p < 88) act = mlfq_pkg::ACT_RUN_DONE;
      else if (p < 96) act = mlfq_pkg::ACT_LEAVE;
      else             act = 3'($urandom_range(5, 7));
      return make_beat(act, s, $urandom_range(0, 1), el, $urandom_range(0, 3) != 0);
   endfunction

   // driver: present the oldest pending beat after a random gap
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            sched_results.push_back(schedule(req_if.payload));
            void'(pending_beats.pop_front());
            send_gap = quiet ? 0 : $urandom_range(0, 5);
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= pending_beats[0];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall at random, compare each beat with the oldest prediction
   int                stall;
   mlfq_pkg::rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (sched_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %p", rsp_if.payload);
            end else begin
               want = sched_results.pop_front();
               if (rsp_if.payload !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_if.payload);
               end
            end
            stall = quiet ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_if.valid || sched_results.size() != 0);
   endtask

   task automatic write_reg(mlfq_pkg::csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx == mlfq_pkg::CSR_THRESHOLD) sh_thr = value;
      else sh_slice[idx - mlfq_pkg::CSR_SLICE0] = value[7:0];
   endtask

   task automatic apply_settings(logic [15:0] thr, logic [7:0] s0, logic [7:0] s1,
                                 logic [7:0] s2, logic [7:0] s3);
      wait_drained();
      write_reg(mlfq_pkg::CSR_THRESHOLD, thr);
      write_reg(mlfq_pkg::CSR_SLICE0, {8'($urandom), s0});
      write_reg(mlfq_pkg::CSR_SLICE1, {8'($urandom), s1});
      write_reg(mlfq_pkg::CSR_SLICE2, {8'($urandom), s2});
      write_reg(mlfq_pkg::CSR_SLICE3, {8'($urandom), s3});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      errors = 0;
      cycles = 0;
      quiet  = 1'b0;
      sh_now = '0;
      order_next = 0;
      sh_thr = 16'd30;
      sh_slice[0] = 8'd1; sh_slice[1] = 8'd3; sh_slice[2] = 8'd9; sh_slice[3] = 8'd15;
      for (int i = 0; i < 64; i++) begin
         sh_level[i] = '0; sh_entry[i] = '0; sh_queued[i] = 1'b0; sh_order[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pick, ignores, saturation at both ends, bad actions
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_PICK, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_TICK, 63, 1, 255, 1));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_LEAVE, 5, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_READY, 63, 1, 255, 1));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_READY, 63, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_RUN_DONE, 63, 0, 255, 1));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_READY, 0, 1, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_READY, 7, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_LEAVE, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_PICK, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_RUN_DONE, 63, 0, 255, 1));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_PICK, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_RUN_DONE, 63, 0, 0, 1));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_PICK, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_RUN_DONE, 63, 1, 255, 0));
      pending_beats.push_back(make_beat(3'd5, 63, 1, 255, 1));
      pending_beats.push_back(make_beat(3'd6, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(3'd7, 1, 0, 0, 0));
      for (int i = 0; i < 31; i++)
         pending_beats.push_back(make_beat(mlfq_pkg::ACT_TICK, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_PICK, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_PICK, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(mlfq_pkg::ACT_PICK, 0, 0, 0, 0));

      // random phases over several register settings
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: apply_settings(16'd30, 8'd1, 8'd3, 8'd9, 8'd15);
            1: apply_settings(16'd1, 8'd1, 8'd1, 8'd1, 8'd1);
            2: apply_settings(16'd65535, 8'd255, 8'd255, 8'd255, 8'd255);
            3: apply_settings(16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
            4: apply_settings(16'd4, 8'd2, 8'd6, 8'd12, 8'd20);
            5: apply_settings(16'($urandom_range(1, 12)), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
            default: apply_settings(16'($urandom), 8'($urandom_range(0, 8)),
                                    8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                                    8'($urandom_range(0, 8)));
         endcase
         quiet = (ph == 4);
         for (int n = 0; n < RANDOM_ITEMS / 7; n++) pending_beats.push_back(random_beat());
      end

      wait_drained();
      repeat (300) @(negedge clock);
      if (errors == 0 && sched_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
